// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the cipher RTL
// Concurrent checks clocked on the rising edge and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pstc_pkg.sv =====
// ---------------------------------------------------------------------------
// pstc_pkg
// Types, constants and arithmetic helpers of the printable shift cipher.
// ---------------------------------------------------------------------------
package pstc_pkg;

    localparam int unsigned MODULUS      = 94;
    localparam int unsigned PRINT_BASE   = 32;
    localparam int unsigned PRINT_TOP    = 126;
    localparam int unsigned WRAP_ADD     = 62;
    localparam int unsigned PICK_STEP    = 25;
    localparam int unsigned DIGIT_BIAS   = 18;     // 50 - 32 in the header digit check
    localparam int unsigned CHANNEL_SPAN = 10000;
    localparam int unsigned MAX_RESULTS  = 6;
    localparam int unsigned STEP_RECIP   = 89241;  // ceil(2^23 / 94)
    localparam int unsigned STEP_SHIFT   = 23;

    localparam logic [2:0] POS_OFFSET = 3'd4;
    localparam logic [2:0] POS_BODY   = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_SHORT    = 2'd2
    } pstc_status_t;

    typedef enum logic [1:0] {
        REG_DIRECTION = 2'd0,
        REG_CHANNEL   = 2'd1,
        REG_STEP      = 2'd2
    } pstc_reg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       msg_last;
        logic [6:0] seed_offset;
        logic [1:0] pick_a;
        logic [1:0] pick_b;
        logic [1:0] pick_c;
        logic [1:0] pick_d;
    } pstc_item_t;

    typedef struct packed {
        logic             direction;
        logic [3:0][3:0]  digit;      // digit[0] is the thousands digit
        logic [6:0]       step_mod;   // step_factor mod 94
    } pstc_cfg_t;

    typedef struct packed {
        logic [7:0]   out_byte;
        logic         byte_valid;
        pstc_status_t status;
    } pstc_rec_t;

    typedef struct packed {
        logic [2:0]                       count;
        logic                             msg_last;
        pstc_rec_t [MAX_RESULTS-1:0]      rec;
    } pstc_set_t;

    // Reduce a value below 6*94 into 0..93.
    function automatic logic [6:0] pstc_mod94(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        for (int q = 1; q <= 5; q++) begin
            if (v >= 9'(q * MODULUS))
                r = v - 9'(q * MODULUS);
        end
        return r[6:0];
    endfunction

    // 16-bit value mod 94 through a reciprocal multiply; exact over the full range.
    function automatic logic [6:0] pstc_step_mod(input logic [15:0] x);
        logic [32:0] prod;
        logic [9:0]  quo;
        logic [15:0] rem;
        prod = 33'(x) * 33'(STEP_RECIP);
        quo  = prod[STEP_SHIFT+9:STEP_SHIFT];
        rem  = x - 16'(quo) * 16'(MODULUS);
        return rem[6:0];
    endfunction

    // Four decimal digits of the channel taken mod 10000, thousands first.
    function automatic logic [3:0][3:0] pstc_digits(input logic [13:0] x);
        logic [13:0]     ch;
        logic [13:0]     r1;
        logic [13:0]     r2;
        logic [3:0][3:0] dg;
        ch = (x >= 14'(CHANNEL_SPAN)) ? x - 14'(CHANNEL_SPAN) : x;
        dg = '0;
        r1 = ch;
        for (int d = 1; d <= 9; d++) begin
            if (ch >= 14'(d * 1000))
            begin
                dg[0] = 4'(d);
                r1    = ch - 14'(d * 1000);
            end
        end
        r2 = r1;
        for (int d = 1; d <= 9; d++) begin
            if (r1 >= 14'(d * 100))
            begin
                dg[1] = 4'(d);
                r2    = r1 - 14'(d * 100);
            end
        end
        dg[3] = r2[3:0];
        for (int d = 1; d <= 9; d++) begin
            if (r2 >= 14'(d * 10))
            begin
                dg[2] = 4'(d);
                dg[3] = 4'(r2 - 14'(d * 10));
            end
        end
        return dg;
    endfunction

endpackage

// ===== rtl/pstc_regs.sv =====
// ---------------------------------------------------------------------------
// pstc_regs
// APB register file; pre-reduces channel and step values at write time.
// ---------------------------------------------------------------------------
module pstc_regs
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output pstc_pkg::pstc_cfg_t  cfg
);
    import pstc_pkg::*;

    logic            direction_reg;
    logic [13:0]     channel_reg;
    logic [15:0]     step_reg;
    logic [3:0][3:0] digit_reg;
    logic [6:0]      step_mod_reg;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            channel_reg   <= '0;
            step_reg      <= '0;
            digit_reg     <= '0;
            step_mod_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_DIRECTION: direction_reg <= pwdata[0];
                REG_CHANNEL:
                begin
                    channel_reg <= pwdata[13:0];
                    digit_reg   <= pstc_digits(pwdata[13:0]);
                end
                REG_STEP:
                begin
                    step_reg     <= pwdata[15:0];
                    step_mod_reg <= pstc_step_mod(pwdata[15:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DIRECTION: prdata = {31'b0, direction_reg};
            REG_CHANNEL:   prdata = {18'b0, channel_reg};
            REG_STEP:      prdata = {16'b0, step_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.direction = direction_reg;
    assign cfg.digit     = digit_reg;
    assign cfg.step_mod  = step_mod_reg;

endmodule

// ===== rtl/pstc_core.sv =====
// ---------------------------------------------------------------------------
// pstc_core
// Message state and the single-pass result logic for one byte.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pstc_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  pstc_pkg::pstc_item_t  item,
    input  pstc_pkg::pstc_cfg_t   cfg,
    output pstc_pkg::pstc_set_t   set
);
    import pstc_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic [6:0] off_reg, off_next;
    logic       any_reg, any_next;
    logic       rej_reg, rej_next;

    logic [3:0][1:0] pick;
    logic [6:0]      seed_mod;
    logic [6:0]      off_base;
    logic [6:0]      off_adv;
    logic [7:0]      adv_sum;
    logic [8:0]      enc_sum;
    logic [7:0]      enc_byte;
    logic [8:0]      diff;
    logic            digit_hit;
    logic [9:0]      dec_diff;
    logic [9:0]      dec_val;
    pstc_rec_t       body_rec;
    pstc_rec_t       end_rec;

    assign pick     = {item.pick_d, item.pick_c, item.pick_b, item.pick_a};
    assign seed_mod = (item.seed_offset >= 7'(MODULUS)) ?
                      item.seed_offset - 7'(MODULUS) : item.seed_offset;

    // Encrypt restarts from the seed while the header is still owed.
    assign off_base = (cfg.direction && pos_reg < POS_BODY) ? seed_mod : off_reg;
    assign adv_sum  = {1'b0, off_base} + {1'b0, cfg.step_mod};
    assign off_adv  = (adv_sum >= 8'(MODULUS)) ? 7'(adv_sum - 8'(MODULUS)) : adv_sum[6:0];

    // Encrypt: add the offset and fold sums above the printable top.
    assign enc_sum  = {1'b0, item.data_byte} + {2'b0, off_adv};
    assign enc_byte = (enc_sum > 9'(PRINT_TOP)) ?
                      {1'b0, pstc_mod94(enc_sum + 9'(WRAP_ADD))} + 8'(PRINT_BASE) :
                      enc_sum[7:0];

    // Decrypt: subtract the offset, add one modulus back below the base.
    assign dec_diff = {2'b0, item.data_byte} - {3'b0, off_adv};
    assign dec_val  = ($signed(dec_diff) < $signed(10'(PRINT_BASE))) ?
                      dec_diff + 10'(MODULUS) : dec_diff;

    // Header digit: (byte + 18 - digit) is a multiple of 25.
    assign diff = {1'b0, item.data_byte} + 9'(DIGIT_BIAS) - {5'b0, cfg.digit[pos_reg[1:0]]};

    always_comb
    begin
        digit_hit = 1'b0;
        for (int m = 0; m <= 10; m++) begin
            if (diff == 9'(m * PICK_STEP))
                digit_hit = 1'b1;
        end
    end

    always_comb
    begin
        body_rec            = '0;
        body_rec.byte_valid = 1'b1;
        body_rec.status     = STATUS_OK;
        body_rec.out_byte   = cfg.direction ? enc_byte : dec_val[7:0];

        end_rec             = '0;
        end_rec.byte_valid  = 1'b0;
        end_rec.status      = STATUS_OK;

        set          = '0;
        set.msg_last = item.msg_last;
        pos_next     = pos_reg;
        off_next     = off_reg;
        any_next     = any_reg;
        rej_next     = rej_reg;

        if (cfg.direction)
        begin
            off_next = off_adv;
            if (pos_reg < POS_BODY)
            begin
                for (int p = 0; p < 4; p++) begin
                    set.rec[p].out_byte   = {6'b0, pick[p]} * 8'(PICK_STEP) +
                                            8'(PRINT_BASE) + {4'b0, cfg.digit[p]};
                    set.rec[p].byte_valid = 1'b1;
                    set.rec[p].status     = STATUS_OK;
                end
                set.rec[4].out_byte   = {1'b0, seed_mod} + 8'(PRINT_BASE);
                set.rec[4].byte_valid = 1'b1;
                set.rec[4].status     = STATUS_OK;
                set.rec[5]            = body_rec;
                set.count             = 3'(MAX_RESULTS);
                pos_next              = POS_BODY;
            end
            else
            begin
                set.rec[0] = body_rec;
                set.count  = 3'd1;
            end
        end
        else if (pos_reg < POS_OFFSET)
        begin
            any_next = any_reg | digit_hit;
            pos_next = pos_reg + 3'd1;
            if (pos_next == POS_OFFSET && !any_next)
                rej_next = 1'b1;
            end_rec.status = rej_next ? STATUS_REJECTED : STATUS_SHORT;
            if (item.msg_last)
            begin
                set.rec[0] = end_rec;
                set.count  = 3'd1;
            end
        end
        else if (pos_reg == POS_OFFSET)
        begin
            if (!rej_reg)
                off_next = pstc_mod94({1'b0, item.data_byte} + 9'(WRAP_ADD));
            pos_next       = POS_BODY;
            end_rec.status = rej_reg ? STATUS_REJECTED : STATUS_OK;
            if (item.msg_last)
            begin
                set.rec[0] = end_rec;
                set.count  = 3'd1;
            end
        end
        else if (rej_reg)
        begin
            end_rec.status = STATUS_REJECTED;
            if (item.msg_last)
            begin
                set.rec[0] = end_rec;
                set.count  = 3'd1;
            end
        end
        else
        begin
            off_next   = off_adv;
            set.rec[0] = body_rec;
            set.count  = 3'd1;
        end

        if (item.msg_last)
        begin
            pos_next = '0;
            any_next = 1'b0;
            rej_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            off_reg <= '0;
            any_reg <= 1'b0;
            rej_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            off_reg <= off_next;
            any_reg <= any_next;
            rej_reg <= rej_next;
        end
    end

    `ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg <= POS_BODY, "header position out of range")
    `ASSERT_ALWAYS(a_off_range, clk, rst_n, off_reg < 7'(MODULUS), "running offset not below 94")
    `ASSERT_NEXT(a_last_clears, clk, rst_n, fire && item.msg_last, pos_reg == '0 && !any_reg && !rej_reg, "message end left header state behind")

endmodule

// ===== rtl/pstc_outq.sv =====
// ---------------------------------------------------------------------------
// pstc_outq
// Result register: holds one byte's results and hands them out in order.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pstc_outq
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pstc_pkg::pstc_set_t  set,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [7:0] out_byte, [8] run_last
    output logic                 m_tlast,
    output logic [2:0]           m_tuser    // [0] byte_valid, [2:1] status
);
    import pstc_pkg::*;

    pstc_rec_t [MAX_RESULTS-1:0] rec_reg;
    logic [2:0]                  cnt_reg;
    logic [2:0]                  idx_reg;
    logic                        last_reg;
    logic                        busy_reg;
    logic                        last_slot;
    pstc_rec_t                   cur;

    assign last_slot = (idx_reg == cnt_reg - 3'd1);
    assign can_load  = !busy_reg || (m_tready && last_slot);
    assign cur       = rec_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idx_reg  <= '0;
            last_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg  <= set.count;
            idx_reg  <= '0;
            last_reg <= set.msg_last;
            busy_reg <= (set.count != '0);
        end
        else if (busy_reg && m_tready)
        begin
            if (last_slot)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= set.rec;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {7'b0, last_slot, cur.out_byte};
    assign m_tlast  = last_slot & last_reg;
    assign m_tuser  = {cur.status, cur.byte_valid};

    `ASSERT_IMPL(a_idx_in_set, clk, rst_n, busy_reg, idx_reg < cnt_reg && cnt_reg <= 3'(MAX_RESULTS), "result index outside loaded set")
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, busy_reg && !m_tready, busy_reg && $stable(idx_reg), "pending result dropped on stall")

endmodule

// ===== rtl/printable_shift_text_cipher.sv =====
// ---------------------------------------------------------------------------
// printable_shift_text_cipher
// Running-offset cipher over printable text, one message byte per transfer.
// ---------------------------------------------------------------------------
// Each transfer on the slave stream carries one message byte; s_tlast marks
// the final byte of a message. With direction set to 1 the block encrypts:
// the first byte of a message first produces a five-byte header (four
// channel digit bytes offset by pick*25+32, then seed+32), then every byte
// gives one cipher byte shifted by a running offset that advances by
// step_factor mod 94. With direction 0 it decrypts: the four digit bytes are
// checked against the channel (the header is rejected only if none match),
// the fifth byte loads the offset, and each body byte gives one plain byte.
// End markers (tuser byte_valid low) report a rejected header or a message
// that stopped inside its header. Master tlast is high on the final result
// of a message; tdata bit 8 is high on the last result caused by one byte.
// Flow: an accepted byte lands in the input register and is processed in one
// pass into the result register when that register is free or empties, and
// its first result is offered from there. The result register hands out one
// result per cycle while m_tready is high, so bytes that give one result
// stream at one per cycle when the output does not stall; the first byte of
// an encrypted message holds the result register for its six results, and
// header bytes in decrypt mode that give no result never occupy it.
// Configure registers only while no message byte is in flight.
// ---------------------------------------------------------------------------
module printable_shift_text_cipher
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [14:8] seed_offset, [16:15] pick_a, [18:17] pick_b,
    // [20:19] pick_c, [22:21] pick_d, [23] zero
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,   // msg_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic        m_tlast,   // msg_end
    output logic [2:0]  m_tuser,   // [0] byte_valid, [2:1] status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pstc_pkg::*;

    pstc_cfg_t  cfg;
    pstc_item_t item_reg;
    logic       in_valid_reg;
    logic       can_load;
    logic       fire;
    pstc_set_t  set;

    // Register file; channel digits and step mod 94 are ready the cycle after a write.
    pstc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Process the held byte whenever the result register is free or empties
    // this cycle; take a new byte whenever none is held or the held one moves on.
    assign fire     = in_valid_reg & can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    // Capture the payload on every input transfer.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.data_byte   <= s_tdata[7:0];
            item_reg.msg_last    <= s_tlast;
            item_reg.seed_offset <= s_tdata[14:8];
            item_reg.pick_a      <= s_tdata[16:15];
            item_reg.pick_b      <= s_tdata[18:17];
            item_reg.pick_c      <= s_tdata[20:19];
            item_reg.pick_d      <= s_tdata[22:21];
        end
    end

    // Message state and the per-byte result logic.
    pstc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .set   (set)
    );

    // Result register and serializer toward the master stream.
    pstc_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .set      (set),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/tb_printable_shift_text_cipher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_printable_shift_text_cipher
// Self-checking bench for the printable running-offset cipher.
// ---------------------------------------------------------------------------
// Message bytes go in on the slave stream, the configuration goes in over
// the APB port, and every result transfer on the master stream is checked
// against a cycle-free prediction of the cipher kept inside the bench. The
// run covers encrypt headers and wrap-around, the decrypt header check with
// its rejected and short cases, a direction change inside a message, random
// traffic under several settings, and a long result stall that backs the
// block up into its input.
// ---------------------------------------------------------------------------
module tb_printable_shift_text_cipher;

    import pstc_pkg::*;

    // Integer copies of the cipher constants, so signed math stays signed.
    localparam int MOD  = int'(MODULUS);
    localparam int BASE = int'(PRINT_BASE);
    localparam int TOP  = int'(PRINT_TOP);
    localparam int WRAP = int'(WRAP_ADD);
    localparam int PICK = int'(PICK_STEP);

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;     // lets no-result bytes clear, plus margin
    localparam int PHASE_ITEMS   = 12;
    localparam int MAX_REPORTS   = 10;

    // One result as seen on the master stream.
    typedef struct packed {
        logic [7:0]   out_byte;
        logic         byte_valid;
        logic         run_last;
        logic         msg_end;
        pstc_status_t status;
    } cipher_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] data_byte, [14:8] seed_offset, [16:15] pick_a,
                            // [18:17] pick_b, [20:19] pick_c, [22:21] pick_d, [23] zero
    logic        s_tlast;   // msg_last

    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_byte, [8] run_last, [15:9] zero
    logic        m_tlast;   // msg_end
    logic [2:0]  m_tuser;   // [0] byte_valid, [2:1] status

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    printable_shift_text_cipher dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Cipher prediction: shadow registers and message state
    // -----------------------------------------------------------------------
    logic        cfg_encrypt = 1'b0;
    logic [13:0] cfg_channel = '0;
    logic [15:0] cfg_step    = '0;

    logic [2:0]  hdr_pos     = '0;   // 0..3 digit bytes, 4 offset byte, 5 body
    logic [6:0]  run_offset  = '0;
    logic        digit_hit   = 1'b0;
    logic        hdr_reject  = 1'b0;

    cipher_byte_t expected_bytes [$];   // results still owed by the block
    logic [7:0]   msg_bytes      [$];   // message being assembled for sending

    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    bit          sender_idle_on = 1'b0;
    bit          ready_idle_on  = 1'b0;
    int unsigned hold_request   = 0;

    // Decimal digit of the channel key, thousands first.
    function automatic int key_digit(input int pos);
        int ch;
        ch = int'(cfg_channel) % int'(CHANNEL_SPAN);
        case (pos)
            0:       return ch / 1000;
            1:       return (ch / 100) % 10;
            2:       return (ch / 10) % 10;
            default: return ch % 10;
        endcase
    endfunction

    function automatic cipher_byte_t byte_rec(input logic [7:0] b, input logic valid,
                                              input pstc_status_t st);
        cipher_byte_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.run_last   = 1'b0;
        r.msg_end    = 1'b0;
        r.status     = st;
        return r;
    endfunction

    function automatic void bump_offset();
        run_offset = 7'((int'(run_offset) + int'(cfg_step) % MOD) % MOD);
    endfunction

    // Work out the results that one accepted byte causes and queue them.
    function automatic void predict_cipher_bytes(input pstc_item_t it);
        cipher_byte_t outs [$];
        cipher_byte_t tail;
        logic [1:0]   picks [4];
        int           sum;
        int           plain;
        picks[0] = it.pick_a;
        picks[1] = it.pick_b;
        picks[2] = it.pick_c;
        picks[3] = it.pick_d;
        if (cfg_encrypt)
        begin
            // A message still in its header state gets a fresh five-byte header.
            if (hdr_pos < POS_BODY)
            begin
                run_offset = 7'(int'(it.seed_offset) % MOD);
                for (int p = 0; p < 4; p++)
                begin
                    outs.push_back(byte_rec(8'(int'(picks[p]) * PICK + BASE + key_digit(p)),
                                            1'b1, STATUS_OK));
                end
                outs.push_back(byte_rec(8'(int'(run_offset) + BASE), 1'b1, STATUS_OK));
                hdr_pos = POS_BODY;
            end
            bump_offset();
            sum = int'(it.data_byte) + int'(run_offset);
            if (sum > TOP)
            begin
                sum = (sum + WRAP) % MOD + BASE;
            end
            outs.push_back(byte_rec(8'(sum), 1'b1, STATUS_OK));
        end
        else if (hdr_pos < POS_OFFSET)
        begin
            // Digit byte: any match among the four keeps the header.
            if ((int'(it.data_byte) + 50 - BASE - key_digit(int'(hdr_pos))) % PICK == 0)
            begin
                digit_hit = 1'b1;
            end
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == POS_OFFSET && !digit_hit)
            begin
                hdr_reject = 1'b1;
            end
            if (it.msg_last)
            begin
                outs.push_back(byte_rec(8'd0, 1'b0,
                                        hdr_reject ? STATUS_REJECTED : STATUS_SHORT));
            end
        end
        else if (hdr_pos == POS_OFFSET)
        begin
            if (!hdr_reject)
            begin
                run_offset = 7'((int'(it.data_byte) + WRAP) % MOD);
            end
            hdr_pos = POS_BODY;
            if (it.msg_last)
            begin
                outs.push_back(byte_rec(8'd0, 1'b0,
                                        hdr_reject ? STATUS_REJECTED : STATUS_OK));
            end
        end
        else if (hdr_reject)
        begin
            if (it.msg_last)
            begin
                outs.push_back(byte_rec(8'd0, 1'b0, STATUS_REJECTED));
            end
        end
        else
        begin
            bump_offset();
            plain = int'(it.data_byte) - int'(run_offset) - BASE;
            if (plain < 0)
            begin
                plain += MOD;
            end
            outs.push_back(byte_rec(8'(plain + BASE), 1'b1, STATUS_OK));
        end

        // Mark the closing result of this byte, and of the message.
        if (outs.size() > 0)
        begin
            tail = outs.pop_back();
            tail.run_last = 1'b1;
            tail.msg_end  = it.msg_last;
            outs.push_back(tail);
        end
        if (it.msg_last)
        begin
            hdr_pos    = '0;
            digit_hit  = 1'b0;
            hdr_reject = 1'b0;
        end
        foreach (outs[i])
        begin
            expected_bytes.push_back(outs[i]);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic pstc_item_t cipher_item(input logic [7:0] data, input logic last,
                                               input logic [6:0] seed,
                                               input logic [1:0] pa, input logic [1:0] pb,
                                               input logic [1:0] pc, input logic [1:0] pd);
        pstc_item_t it;
        it.data_byte   = data;
        it.msg_last    = last;
        it.seed_offset = seed;
        it.pick_a      = pa;
        it.pick_b      = pb;
        it.pick_c      = pc;
        it.pick_d      = pd;
        return it;
    endfunction

    // Header digit byte for the current channel, matching or deliberately not.
    function automatic logic [7:0] digit_byte(input int pos, input bit good);
        int lift;
        lift = PICK * int'($urandom_range(0, 3));
        if (good)
        begin
            return 8'(lift + BASE + key_digit(pos));
        end
        return 8'(lift + BASE + key_digit(pos) + int'($urandom_range(1, 24)));
    endfunction

    // Offer one byte, hold it until the transfer, then predict its results.
    task automatic send_item(input pstc_item_t it);
        int unsigned gap;
        gap = sender_idle_on ? idle_gap() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.pick_d, it.pick_c, it.pick_b, it.pick_a,
                     it.seed_offset, it.data_byte};
        s_tlast  <= it.msg_last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_cipher_bytes(it);
        items_sent++;
    endtask

    // Send a byte with random seed and picks.
    task automatic send_byte(input logic [7:0] data, input logic last);
        send_item(cipher_item(data, last, 7'($urandom_range(0, 127)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))));
    endtask

    // Send the assembled message, tlast on its final byte.
    task automatic send_msg_bytes();
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            send_byte(msg_bytes[i], i == n - 1);
        end
        msg_bytes.delete();
    endtask

    // Drop valid, drain every owed result, then let no-result bytes clear.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then release the bus.
    task automatic reg_write(input pstc_reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_DIRECTION: cfg_encrypt = value[0];
            REG_CHANNEL:   cfg_channel = value[13:0];
            REG_STEP:      cfg_step    = value[15:0];
            default:       ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic dir, input logic [13:0] ch, input logic [15:0] step);
        reg_write(REG_DIRECTION, {31'd0, dir});
        reg_write(REG_CHANNEL,   {18'd0, ch});
        reg_write(REG_STEP,      {16'd0, step});
    endtask

    // Random plaintext: mostly short messages, now and then a longer one.
    task automatic queue_random_encrypt_msg();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Random ciphertext: mostly well-formed, the rest rejected, cut or noise.
    task automatic queue_random_decrypt_msg();
        int kind;
        int cut;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            for (int p = 0; p < 4; p++)
            begin
                msg_bytes.push_back(digit_byte(p, $urandom_range(0, 9) != 0));
            end
            msg_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(32, 126)));
            repeat ($urandom_range(0, 6))
            begin
                msg_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                                 : 8'($urandom_range(32, 126)));
            end
        end
        else if (kind < 8)
        begin
            // Every digit byte off: the rest of the message is swallowed.
            for (int p = 0; p < 4; p++)
            begin
                msg_bytes.push_back(digit_byte(p, 1'b0));
            end
            repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 8)
        begin
            // Good header cut short, up to and including the fourth digit.
            cut = $urandom_range(1, 4);
            for (int p = 0; p < cut; p++)
            begin
                msg_bytes.push_back(digit_byte(p, 1'b1));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Header with extreme picks and seeds, then bytes that wrap past 126.
    task automatic test_encrypt_header_and_wrap();
        configure(1'b1, 14'd9999, 16'hFFFF);
        send_item(cipher_item(8'h00, 1'b1, 7'd0, 2'd0, 2'd0, 2'd0, 2'd0));
        send_item(cipher_item(8'hFF, 1'b0, 7'd127, 2'd3, 2'd3, 2'd3, 2'd3));
        send_item(cipher_item(8'd126, 1'b0, 7'd94, 2'd1, 2'd2, 2'd1, 2'd2));
        send_item(cipher_item(8'd127, 1'b0, 7'd93, 2'd2, 2'd1, 2'd2, 2'd1));
        send_item(cipher_item(8'd95, 1'b1, 7'd64, 2'd0, 2'd3, 2'd0, 2'd3));
        wait_until_idle();
    endtask

    // Header check: malformed offset, short message, rejection, empty body.
    task automatic test_decrypt_header_checks();
        configure(1'b0, 14'h3FFF, 16'd0);
        // first digit wrong, offset byte 0 taken modulo, zero and 255 in the body
        for (int p = 0; p < 4; p++)
        begin
            msg_bytes.push_back(digit_byte(p, p != 0));
        end
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        send_msg_bytes();
        // ends inside the header
        msg_bytes.push_back(digit_byte(0, 1'b1));
        msg_bytes.push_back(digit_byte(1, 1'b1));
        send_msg_bytes();
        // all four digits wrong, ends on the fourth
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        msg_bytes.push_back(digit_byte(2, 1'b0));
        msg_bytes.push_back(digit_byte(3, 1'b0));
        send_msg_bytes();
        // rejected header, ends on the offset byte
        for (int p = 0; p < 4; p++)
        begin
            msg_bytes.push_back(digit_byte(p, 1'b0));
        end
        msg_bytes.push_back(8'd65);
        send_msg_bytes();
        wait_until_idle();
    endtask

    // Flip direction between bytes of one message.
    task automatic test_direction_switch();
        configure(1'b0, 14'd0, 16'd93);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_until_idle();
        // header state still open, so encrypt emits a header
        reg_write(REG_DIRECTION, 32'd1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_until_idle();
        // back to decrypt with the body state and offset left by encrypt
        reg_write(REG_DIRECTION, 32'd0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_until_idle();
    endtask

    // Random messages under several settings; the first phase runs without gaps.
    task automatic test_random_messages();
        int start;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_until_idle();
            sender_idle_on = (phase != 0);
            ready_idle_on  = (phase != 0);
            case (phase)
                0: configure(1'b0, 14'd9999, 16'hFFFF);
                1: configure(1'b1, 14'd0, 16'd0);
                2: configure(1'b0, 14'($urandom_range(0, 16383)),
                             16'($urandom_range(0, 65535)));
                3: configure(1'b1, 14'h3FFF, 16'd94);
                4: configure(1'b0, 14'd0, 16'd93);
                default: configure(1'b1, 14'($urandom_range(0, 16383)),
                                   16'($urandom_range(0, 65535)));
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if (cfg_encrypt)
                begin
                    queue_random_encrypt_msg();
                end
                else
                begin
                    queue_random_decrypt_msg();
                end
                send_msg_bytes();
            end
        end
        wait_until_idle();
    endtask

    // Hold the result side off for a long stretch while bytes keep coming.
    task automatic test_input_backpressure();
        configure(1'b1, 14'($urandom_range(0, 9999)), 16'($urandom_range(0, 65535)));
        sender_idle_on = 1'b0;
        ready_idle_on  = 1'b1;
        hold_request   = 250;
        repeat (5)
        begin
            repeat (8) msg_bytes.push_back(8'($urandom_range(0, 255)));
            send_msg_bytes();
        end
        wait_until_idle();
    endtask

    // -----------------------------------------------------------------------
    // Result side: ready pattern and checker
    // -----------------------------------------------------------------------

    // Each pass drives ready once and holds it for a run of cycles.
    initial
    begin : result_ready_gen
        int unsigned span;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request != 0)
            begin
                span = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
            end
            else if (ready_idle_on && $urandom_range(0, 2) == 0)
            begin
                span = idle_gap();
                m_tready <= 1'b0;
            end
            else
            begin
                span = $urandom_range(1, 12);
                m_tready <= 1'b1;
            end
            if (span == 0)
            begin
                span = 1;
            end
            repeat (span) @(posedge clk);
        end
    end

    // Compare every result transfer with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        cipher_byte_t want;
        cipher_byte_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.out_byte   = m_tdata[7:0];
            got.byte_valid = m_tuser[0];
            got.run_last   = m_tdata[8];
            got.msg_end    = m_tlast;
            got.status     = pstc_status_t'(m_tuser[2:1]);
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result byte %02h valid %0d status %0d",
                             $realtime, got.out_byte, got.byte_valid, got.status);
                end
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.run_last !== want.run_last || got.msg_end !== want.msg_end ||
                    got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  expected byte %02h valid %0d run_last %0d end %0d st %0d",
                                 want.out_byte, want.byte_valid, want.run_last,
                                 want.msg_end, want.status);
                        $display("  actual   byte %02h valid %0d run_last %0d end %0d st %0d",
                                 got.out_byte, got.byte_valid, got.run_last,
                                 got.msg_end, got.status);
                    end
                end
            end
        end
    end

    // Cycle limit: abandon the run if traffic stops moving.
    initial
    begin : cycle_watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin : main_sequence
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_encrypt_header_and_wrap();
        test_decrypt_header_checks();
        test_direction_switch();
        test_random_messages();
        test_input_backpressure();

        wait_until_idle();
        if (expected_bytes.size() != 0)
        begin
            $display("results still owed: %0d", expected_bytes.size());
        end
        if (mismatch_count == 0 && expected_bytes.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
